[rtl/core/thrr_pkg.sv]
// shared types and constants for the timestamped history ring resampler
package thrr_pkg;

    // fixed field widths
    localparam int PAYLOAD_W   = 32;
    localparam int TIME_W      = 64;
    localparam int GEN_W       = 32;
    localparam int PERIOD_W    = 32;
    localparam int REQ_W       = 3;
    localparam int COUNT_W     = 5;

    // default configuration
    localparam int DEF_HISTORY_DEPTH = 16;
    localparam int DEF_MAX_READ      = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUBLISH  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LATEST   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RECENT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESAMPLE = 3'd4;

    // one history entry as held in the ring memory
    typedef struct packed {
        logic [GEN_W-1:0]     generation;
        logic [TIME_W-1:0]    timestamp;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

endpackage

[rtl/core/timestamped_history_ring_resampler_core.sv]
// timestamped history ring with recent-read and nearest-timestamp resampling
//
// Usage: requests arrive on the s_ channel (valid/ready); results leave on the
// m_ channel (valid/ready), one transaction per result, last_item marking the
// final result of a query. Publish and clear give no result; codes above
// resample are dropped. The sample period register is written through cfg_wr_en
// and cfg_wr_data; the user must do so only while the block is idle, which the
// block itself does not enforce.
// Throughput: one request at a time. Publish and clear may follow each other
// every cycle. Read latest and read recent issue one ring read per returned
// entry. Each resampled output scans every filled entry through the single read
// port of the ring memory, one entry per cycle. No new request is taken until
// the last result of a query has been loaded into the output register.
// Sequence: an empty answer is loaded from ST_EMPTY; reads pass ST_RD_ISSUE and
// ST_RD_WAIT per entry; a resampled run passes ST_ANC_ISSUE, ST_ANC_WAIT, ST_MUL,
// ST_TGT, ST_SCAN and ST_RS_EMIT, each further output again from ST_MUL.
// Reset: clears the fill level, write pointer, generation count and the
// period (to 1000); the ring memory is not cleared, only filled entries are
// read. A stalled receiver holds the output register; the sequencer waits and
// no result is lost or repeated.
module timestamped_history_ring_resampler_core #(
    parameter int HISTORY_DEPTH = thrr_pkg::DEF_HISTORY_DEPTH,
    parameter int MAX_READ      = thrr_pkg::DEF_MAX_READ
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [thrr_pkg::PERIOD_W-1:0]   cfg_wr_data,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [thrr_pkg::REQ_W-1:0]      s_req_type,
    input  logic [thrr_pkg::PAYLOAD_W-1:0]  s_payload_in,
    input  logic [thrr_pkg::TIME_W-1:0]     s_timestamp_in,
    input  logic [thrr_pkg::COUNT_W-1:0]    s_read_count,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [thrr_pkg::PAYLOAD_W-1:0]  m_payload_out,
    output logic [thrr_pkg::TIME_W-1:0]     m_timestamp_out,
    output logic [thrr_pkg::GEN_W-1:0]      m_generation_out,
    output logic                            m_valid_res,
    output logic                            m_last_item
);
    import thrr_pkg::*;

    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = CW + 1;
    localparam int NW = $clog2(MAX_READ + 1);
    localparam int QW = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int SW = (NW > CW) ? NW : CW;
    localparam int MW = SW + PERIOD_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_EMPTY     = 4'd1;
    localparam logic [3:0] ST_RD_ISSUE  = 4'd2;
    localparam logic [3:0] ST_RD_WAIT   = 4'd3;
    localparam logic [3:0] ST_ANC_ISSUE = 4'd4;
    localparam logic [3:0] ST_ANC_WAIT  = 4'd5;
    localparam logic [3:0] ST_MUL       = 4'd6;
    localparam logic [3:0] ST_TGT       = 4'd7;
    localparam logic [3:0] ST_SCAN      = 4'd8;
    localparam logic [3:0] ST_RS_EMIT   = 4'd9;

    // ring memory and its registered read port
    entry_t ring_mem [HISTORY_DEPTH];
    entry_t rd_data_reg;
    logic   rd_en;
    logic [PW-1:0] rd_addr;
    logic   wr_en;
    entry_t wr_entry;

    // control state
    logic [3:0]          state_reg, state_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [GEN_W-1:0]    gen_reg, gen_next;
    logic                have_data_reg, have_data_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [CW-1:0]       fill_reg, fill_next;

    // per-query working registers
    logic [PW-1:0]       slot_reg, slot_next;
    logic [PW-1:0]       oldest_reg, oldest_next;
    logic [SW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       h_reg, h_next;
    logic [TIME_W-1:0]   anchor_reg, anchor_next;
    logic [TIME_W-1:0]   offset_reg, offset_next;
    logic [TIME_W-1:0]   target_reg, target_next;

    // scan pipeline
    logic                p1_valid_reg, p1_valid_next;
    logic                dist_valid_reg, dist_valid_next;
    logic [TIME_W-1:0]   dist_reg, dist_next;
    entry_t              dist_entry_reg;
    logic                best_valid_reg, best_valid_next;
    logic [TIME_W-1:0]   best_dist_reg, best_dist_next;
    entry_t              best_entry_reg, best_entry_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    entry_t              out_entry_reg, out_entry_next;
    logic                out_vres_reg, out_vres_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                out_free;
    logic [PW-1:0]       newest;
    logic [NW-1:0]       n_clamp;
    logic [SW-1:0]       n_recent;
    logic [AW-1:0]       oldest_recent_sum;
    logic [AW-1:0]       oldest_all_sum;
    logic [PW-1:0]       oldest_recent;
    logic [PW-1:0]       oldest_all;
    logic [PW-1:0]       slot_inc;
    logic [MW-1:0]       product;
    logic                no_data;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign no_data  = !have_data_reg || (fill_reg == '0);

    // ring address arithmetic
    assign newest   = (wp_reg == '0) ? PW'(HISTORY_DEPTH - 1) : wp_reg - PW'(1);
    assign slot_inc = (slot_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + PW'(1);
    assign n_clamp  = (QW'(s_read_count) > QW'(MAX_READ)) ? NW'(MAX_READ) :
                      NW'(s_read_count);
    assign n_recent = (SW'(n_clamp) > SW'(fill_reg)) ? SW'(fill_reg) : SW'(n_clamp);
    assign oldest_recent_sum = AW'(wp_reg) + AW'(HISTORY_DEPTH) - AW'(n_recent);
    assign oldest_all_sum    = AW'(wp_reg) + AW'(HISTORY_DEPTH) - AW'(fill_reg);
    assign oldest_recent = (oldest_recent_sum >= AW'(HISTORY_DEPTH)) ?
                           PW'(oldest_recent_sum - AW'(HISTORY_DEPTH)) : PW'(oldest_recent_sum);
    assign oldest_all    = (oldest_all_sum >= AW'(HISTORY_DEPTH)) ?
                           PW'(oldest_all_sum - AW'(HISTORY_DEPTH)) : PW'(oldest_all_sum);

    // offset of the current resample target from the anchor
    assign product = MW'(rem_reg) * MW'(period_reg);

    // sequencer and datapath next-state logic
    always_comb begin
        state_next      = state_reg;
        gen_next        = gen_reg;
        have_data_next  = have_data_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        slot_next       = slot_reg;
        oldest_next     = oldest_reg;
        rem_next        = rem_reg;
        h_next          = h_reg;
        anchor_next     = anchor_reg;
        offset_next     = offset_reg;
        target_next     = target_reg;
        p1_valid_next   = 1'b0;
        dist_valid_next = p1_valid_reg;
        dist_next       = (rd_data_reg.timestamp >= target_reg) ?
                          rd_data_reg.timestamp - target_reg :
                          target_reg - rd_data_reg.timestamp;
        best_valid_next = best_valid_reg;
        best_dist_next  = best_dist_reg;
        best_entry_next = best_entry_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_entry_next  = out_entry_reg;
        out_vres_next   = out_vres_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = slot_reg;
        wr_en           = 1'b0;
        wr_entry.generation = gen_reg + GEN_W'(1);
        wr_entry.timestamp  = s_timestamp_in;
        wr_entry.payload    = s_payload_in;

        // best-match update, ties to the later (newer) entry
        if (dist_valid_reg && (!best_valid_reg || dist_reg <= best_dist_reg)) begin
            best_valid_next = 1'b1;
            best_dist_next  = dist_reg;
            best_entry_next = dist_entry_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_PUBLISH: begin
                            wr_en          = 1'b1;
                            gen_next       = gen_reg + GEN_W'(1);
                            wp_next        = (wp_reg == PW'(HISTORY_DEPTH - 1)) ?
                                             '0 : wp_reg + PW'(1);
                            if (fill_reg < CW'(HISTORY_DEPTH)) begin
                                fill_next = fill_reg + CW'(1);
                            end
                            have_data_next = 1'b1;
                        end
                        REQ_CLEAR: begin
                            gen_next       = gen_reg + GEN_W'(1);
                            have_data_next = 1'b0;
                            wp_next        = '0;
                            fill_next      = '0;
                        end
                        REQ_LATEST: begin
                            if (no_data) begin
                                state_next = ST_EMPTY;
                            end else begin
                                slot_next  = newest;
                                rem_next   = '0;
                                state_next = ST_RD_ISSUE;
                            end
                        end
                        REQ_RECENT: begin
                            if (no_data || n_clamp == '0) begin
                                state_next = ST_EMPTY;
                            end else begin
                                slot_next  = oldest_recent;
                                rem_next   = n_recent - SW'(1);
                                state_next = ST_RD_ISSUE;
                            end
                        end
                        REQ_RESAMPLE: begin
                            if (no_data || n_clamp == '0 || period_reg == '0) begin
                                state_next = ST_EMPTY;
                            end else begin
                                slot_next   = newest;
                                oldest_next = oldest_all;
                                rem_next    = SW'(n_clamp) - SW'(1);
                                state_next  = ST_ANC_ISSUE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_entry_next = '0;
                    out_vres_next  = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD_ISSUE: begin
                rd_en      = 1'b1;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_entry_next = rd_data_reg;
                    out_vres_next  = 1'b1;
                    out_last_next  = (rem_reg == '0);
                    if (rem_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rem_next   = rem_reg - SW'(1);
                        slot_next  = slot_inc;
                        state_next = ST_RD_ISSUE;
                    end
                end
            end
            ST_ANC_ISSUE: begin
                rd_en      = 1'b1;
                state_next = ST_ANC_WAIT;
            end
            ST_ANC_WAIT: begin
                anchor_next = rd_data_reg.timestamp;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                offset_next = TIME_W'(product);
                state_next  = ST_TGT;
            end
            ST_TGT: begin
                target_next     = (anchor_reg >= offset_reg) ? anchor_reg - offset_reg : '0;
                best_valid_next = 1'b0;
                slot_next       = oldest_reg;
                h_next          = '0;
                state_next      = ST_SCAN;
            end
            ST_SCAN: begin
                // walk the filled entries oldest first, one read per cycle
                if (h_reg != fill_reg) begin
                    rd_en         = 1'b1;
                    p1_valid_next = 1'b1;
                    h_next        = h_reg + CW'(1);
                    slot_next     = slot_inc;
                end else if (!p1_valid_reg && !dist_valid_reg) begin
                    state_next = ST_RS_EMIT;
                end
            end
            ST_RS_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    out_entry_next = best_entry_reg;
                    out_vres_next  = 1'b1;
                    out_last_next  = (rem_reg == '0);
                    if (rem_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rem_next   = rem_reg - SW'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (rd_en) begin
            rd_addr = slot_reg;
        end
    end

    // ring memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wp_reg] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            period_reg     <= PERIOD_RESET;
            gen_reg        <= '0;
            have_data_reg  <= 1'b0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            p1_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            gen_reg        <= gen_next;
            have_data_reg  <= have_data_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            p1_valid_reg   <= p1_valid_next;
            dist_valid_reg <= dist_valid_next;
            best_valid_reg <= best_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        slot_reg       <= slot_next;
        oldest_reg     <= oldest_next;
        rem_reg        <= rem_next;
        h_reg          <= h_next;
        anchor_reg     <= anchor_next;
        offset_reg     <= offset_next;
        target_reg     <= target_next;
        dist_reg       <= dist_next;
        dist_entry_reg <= rd_data_reg;
        best_dist_reg  <= best_dist_next;
        best_entry_reg <= best_entry_next;
        out_entry_reg  <= out_entry_next;
        out_vres_reg   <= out_vres_next;
        out_last_reg   <= out_last_next;
    end

    // result channel
    assign m_valid          = m_valid_reg;
    assign m_payload_out    = out_entry_reg.payload;
    assign m_timestamp_out  = out_entry_reg.timestamp;
    assign m_generation_out = out_entry_reg.generation;
    assign m_valid_res      = out_vres_reg;
    assign m_last_item      = out_last_reg;

`ifndef SYNTHESIS
    // fill level never exceeds the ring depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(HISTORY_DEPTH))
        else $error("fill level above ring depth");

    // data flag tracks a non-zero fill level
    a_have_data: assert property (@(posedge aclk) disable iff (!aresetn)
        have_data_reg == (fill_reg != '0))
        else $error("data flag out of step with fill level");

    // scan index stays inside the filled region
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (h_reg <= fill_reg))
        else $error("scan index beyond fill level");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pending result dropped");

    // a resampled output is only emitted with a best match in hand
    a_best_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RS_EMIT) |-> best_valid_reg)
        else $error("resample emit without a match");
`endif

endmodule
